// ----- hw/rtl/smav_pkg.sv -----
// Shared types, widths and constants for the sensor moving-average block.
// Used by the channel interfaces, the delay-line cells, the averaging stage and the top level.
// No dependencies.
package smav_pkg;

    // Window length and derived widths
    localparam int WINDOW   = 8;
    localparam int WIN_LOG  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Field widths
    localparam int TEMP_W   = 12;
    localparam int HUMID_W  = 10;
    localparam int COUNT_W  = 8;

    // Reading limits and defaults, in tenths
    localparam int TEMP_MIN      = -400;
    localparam int TEMP_MAX      = 1250;
    localparam int HUMID_MAX     = 1000;
    localparam int TEMP_DEFAULT  = 220;
    localparam int HUMID_DEFAULT = 500;

    // Window sum widths: signed temperature, unsigned humidity
    localparam int TSUM_W = $clog2(TEMP_MAX * WINDOW + 1) + 1;
    localparam int HSUM_W = $clog2(HUMID_MAX * WINDOW + 1);

    // Divide-by-window: temperature sum is offset to be non-negative first
    localparam int TEMP_OFFSET = -TEMP_MIN * WINDOW;
    localparam int TX_W  = $clog2((TEMP_MAX - TEMP_MIN) * WINDOW + 1);
    localparam int HX_W  = HSUM_W;
    localparam int T_SHIFT = TX_W + WIN_LOG;
    localparam int H_SHIFT = HX_W + WIN_LOG;
    localparam int TM_W  = TX_W + 2;
    localparam int HM_W  = HX_W + 2;
    localparam longint unsigned TEMP_MULT =
        ((64'd1 << T_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam longint unsigned HUMID_MULT =
        ((64'd1 << H_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ERROR_LIMIT = 1'b0;   // register index, paddr[2]
    localparam logic [COUNT_W-1:0] ERROR_LIMIT_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef logic signed [TEMP_W-1:0]  temp_t;
    typedef logic        [HUMID_W-1:0] humid_t;
    typedef logic        [COUNT_W-1:0] count_t;
    typedef logic signed [TSUM_W-1:0]  tsum_t;
    typedef logic        [HSUM_W-1:0]  hsum_t;

    // One delay-line entry
    typedef struct packed {
        temp_t  temp;
        humid_t humid;
    } smav_entry_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic fill;
    } smav_cell_ctrl_t;

    // State snapshot handed to the averaging stage
    typedef struct packed {
        logic   flag;
        count_t count;
        tsum_t  tsum;
        hsum_t  hsum;
    } smav_snap_t;

endpackage

// ----- hw/rtl/smav_if.sv -----
// Valid/ready channel interfaces for sensor reads and averaged results.
// Depends on smav_pkg.
interface smav_sample_if;
    import smav_pkg::*;

    logic   valid;
    logic   ready;
    logic   read_ok;
    temp_t  temp_tenths;
    humid_t humid_tenths;

    modport source (output valid, output read_ok, output temp_tenths,
                    output humid_tenths, input ready);
    modport sink   (input valid, input read_ok, input temp_tenths,
                    input humid_tenths, output ready);
endinterface

interface smav_result_if;
    import smav_pkg::*;

    logic   valid;
    logic   ready;
    logic   valid_res;
    temp_t  temp_avg_tenths;
    humid_t humid_avg_tenths;
    count_t error_count;

    modport source (output valid, output valid_res, output temp_avg_tenths,
                    output humid_avg_tenths, output error_count, input ready);
    modport sink   (input valid, input valid_res, input temp_avg_tenths,
                    input humid_avg_tenths, input error_count, output ready);
endinterface

// ----- hw/rtl/smav_cell.sv -----
// One entry of the sample delay line: holds a temperature and a humidity reading.
// Depends on smav_pkg.
module smav_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  smav_pkg::smav_cell_ctrl_t ctrl,
    input  smav_pkg::smav_entry_t     fill_val,
    input  smav_pkg::smav_entry_t     prev,
    output smav_pkg::smav_entry_t     entry
);
    import smav_pkg::*;

    smav_entry_t entry_reg;
    smav_entry_t entry_next;

    // Load the new sample on fill, else take the neighbor's entry on shift
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.fill)
        begin
            entry_next = fill_val;
        end
        else if (ctrl.shift)
        begin
            entry_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/smav_avg.sv -----
// Output stage: registers the window sums divided by the window length, or defaults.
// Depends on smav_pkg and smav_if.
module smav_avg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 snap_valid,
    input  smav_pkg::smav_snap_t snap,
    output logic                 snap_ready,
    smav_result_if.source        result
);
    import smav_pkg::*;

    localparam logic [TM_W-1:0] T_MULT = TM_W'(TEMP_MULT);
    localparam logic [HM_W-1:0] H_MULT = HM_W'(HUMID_MULT);

    logic [TX_W:0]          tx_wide;
    logic [TX_W-1:0]        tx;
    logic [TX_W+TM_W-1:0]   tprod;
    logic [TX_W+TM_W-1:0]   tq_full;
    logic [HX_W+HM_W-1:0]   hprod;
    logic [HX_W+HM_W-1:0]   hq_full;
    temp_t                  tavg;
    humid_t                 havg;

    logic   res_valid_reg;
    logic   flag_reg;
    temp_t  tavg_reg;
    humid_t havg_reg;
    count_t count_reg;
    logic   load;

    // Floor divide: offset temperature to non-negative, multiply by reciprocal
    always_comb
    begin
        tx_wide = (TX_W + 1)'(snap.tsum) + (TX_W + 1)'(TEMP_OFFSET);
        tx      = tx_wide[TX_W-1:0];
        tprod   = (TX_W + TM_W)'(tx) * (TX_W + TM_W)'(T_MULT);
        tq_full = tprod >> T_SHIFT;
        hprod   = (HX_W + HM_W)'(snap.hsum) * (HX_W + HM_W)'(H_MULT);
        hq_full = hprod >> H_SHIFT;
        if (snap.flag)
        begin
            tavg = tq_full[TEMP_W-1:0] + TEMP_W'(TEMP_MIN);
            havg = hq_full[HUMID_W-1:0];
        end
        else
        begin
            tavg = TEMP_W'(TEMP_DEFAULT);
            havg = HUMID_W'(HUMID_DEFAULT);
        end
    end

    assign snap_ready = !res_valid_reg || result.ready;
    assign load       = snap_valid && snap_ready;

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            res_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flag_reg  <= snap.flag;
            tavg_reg  <= tavg;
            havg_reg  <= havg;
            count_reg <= snap.count;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.valid_res        = flag_reg;
    assign result.temp_avg_tenths  = tavg_reg;
    assign result.humid_avg_tenths = havg_reg;
    assign result.error_count      = count_reg;

endmodule

// ----- hw/rtl/sensor_moving_average_validity.sv -----
// Top level of the sensor moving-average filter with read validity tracking.
// Depends on smav_pkg, smav_if, smav_cell and smav_avg.
//
//   channel   kind             carries
//   -------   --------------   ----------------------------------------------
//   sample    valid/ready in   read_ok, temp_tenths, humid_tenths
//   result    valid/ready out  valid_res, temp_avg_tenths, humid_avg_tenths,
//                              error_count
//   apb       config port      error_limit at byte address 0
//
// One sample per cycle is accepted while the result sink keeps up; its result passes
// through the state update and snapshot register, then the reciprocal multiply into
// the output register. The delay line of WINDOW cells shifts on each accepted good read
// (a good first read fills every cell); the window sums add the new reading, drop the
// oldest. Reset clears the cells, sums and counters at once; no sweep. A stalled result
// sink backs up through the snapshot register to sample.ready with no bubbles.
module sensor_moving_average_validity
(
    input  logic                          clk,
    input  logic                          rst_n,
    smav_sample_if.sink                   sample,
    smav_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smav_pkg::PADDR_W-1:0]  paddr,
    input  logic [smav_pkg::PDATA_W-1:0]  pwdata,
    output logic [smav_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import smav_pkg::*;

    // Configuration
    count_t error_limit_reg;

    // Filter state
    tsum_t  tsum_reg;
    tsum_t  tsum_next;
    hsum_t  hsum_reg;
    hsum_t  hsum_next;
    count_t fail_reg;
    count_t fail_next;
    logic   flag_reg;
    logic   flag_next;
    logic   first_reg;

    // Snapshot stage
    logic       snap_valid_reg;
    smav_snap_t snap_reg;
    smav_snap_t snap_next;
    logic       snap_ready;

    logic            accept;
    temp_t           t_clamp;
    humid_t          h_clamp;
    smav_entry_t     new_entry;
    smav_cell_ctrl_t cell_ctrl;
    smav_entry_t     line [WINDOW];

    // Register write and read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_limit_reg <= ERROR_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_ERROR_LIMIT)
        begin
            error_limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ERROR_LIMIT) ? PDATA_W'(error_limit_reg) : '0;
    assign pready = 1'b1;

    assign sample.ready = !snap_valid_reg || snap_ready;
    assign accept       = sample.valid && sample.ready;

    // Clamp readings to the sensor range
    always_comb
    begin
        if (sample.temp_tenths < TEMP_W'(TEMP_MIN))
        begin
            t_clamp = TEMP_W'(TEMP_MIN);
        end
        else if (sample.temp_tenths > TEMP_W'(TEMP_MAX))
        begin
            t_clamp = TEMP_W'(TEMP_MAX);
        end
        else
        begin
            t_clamp = sample.temp_tenths;
        end
        h_clamp = (sample.humid_tenths > HUMID_W'(HUMID_MAX)) ?
                  HUMID_W'(HUMID_MAX) : sample.humid_tenths;
        new_entry.temp  = t_clamp;
        new_entry.humid = h_clamp;
    end

    // Next state: error count, validity, window sums
    always_comb
    begin
        fail_next = fail_reg;
        flag_next = flag_reg;
        tsum_next = tsum_reg;
        hsum_next = hsum_reg;
        cell_ctrl = '0;
        if (!sample.read_ok)
        begin
            if (fail_reg != COUNT_MAX)
            begin
                fail_next = fail_reg + 1'b1;
            end
            if (fail_next >= error_limit_reg)
            begin
                flag_next = 1'b0;
            end
        end
        else
        begin
            fail_next = '0;
            flag_next = 1'b1;
            if (first_reg)
            begin
                tsum_next = TSUM_W'(t_clamp) * TSUM_W'(WINDOW);
                hsum_next = HSUM_W'(h_clamp) * HSUM_W'(WINDOW);
                cell_ctrl.fill = accept;
            end
            else
            begin
                tsum_next = tsum_reg + TSUM_W'(t_clamp) - TSUM_W'(line[WINDOW-1].temp);
                hsum_next = hsum_reg + HSUM_W'(h_clamp) - HSUM_W'(line[WINDOW-1].humid);
                cell_ctrl.shift = accept;
            end
        end
        snap_next.flag  = flag_next;
        snap_next.count = fail_next;
        snap_next.tsum  = tsum_next;
        snap_next.hsum  = hsum_next;
    end

    // Advance filter state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsum_reg  <= '0;
            hsum_reg  <= '0;
            fail_reg  <= '0;
            flag_reg  <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            tsum_reg  <= tsum_next;
            hsum_reg  <= hsum_next;
            fail_reg  <= fail_next;
            flag_reg  <= flag_next;
            first_reg <= 1'b0;
        end
    end

    // Snapshot register in front of the divide stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            snap_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snap_reg <= snap_next;
        end
    end

    // Delay line: cell 0 takes the new sample, the last cell is the oldest
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        smav_entry_t prev;
        if (i == 0)
        begin : g_head
            assign prev = new_entry;
        end
        else
        begin : g_body
            assign prev = line[i-1];
        end
        smav_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .fill_val (new_entry),
            .prev     (prev),
            .entry    (line[i])
        );
    end

    smav_avg u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid_reg),
        .snap       (snap_reg),
        .snap_ready (snap_ready),
        .result     (result)
    );

endmodule
